[rtl/rfdv_pkg.sv]
// Shared types, constants and helpers for the resonant drum voice.
// Used by the digit-serial multiplier, the top level and the testbench.
`default_nettype none

package rfdv_pkg;

  // Q24 fixed point and trigger constants.
  localparam int unsigned Q24Shift = 24;
  localparam logic [24:0] OneQ24   = 25'(1 << Q24Shift);
  localparam int unsigned KickGain = 14;
  localparam int unsigned OutShift = Q24Shift - 14;
  localparam logic [24:0] EnvMax   = '1;

  // Field widths.
  localparam int unsigned VelW   = 32;
  localparam int unsigned NoiseW = 26;
  localparam int unsigned OutW   = 16;
  localparam int unsigned StateW = 32;
  localparam int unsigned CoefW  = 25;
  localparam int unsigned GainW  = 24;
  localparam int unsigned ImpW   = 28;

  // Multiplier geometry: a parallel signed operand times an unsigned operand
  // that is consumed one digit per cycle, least significant digit first.
  localparam int unsigned MulAW     = 32;
  localparam int unsigned MulBW     = 25;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = (MulBW + DigitW - 1) / DigitW;
  localparam int unsigned MulBPadW  = NumDigits * DigitW;
  localparam int unsigned MulAccW   = MulAW + DigitW + 1;
  localparam int unsigned DigCntW   = $clog2(NumDigits);

  // Configuration port.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Reset values of the coefficient registers.
  localparam logic [24:0] FreqReset       = 25'd197175;
  localparam logic [24:0] DampReset       = 25'd2376772;
  localparam logic [24:0] BodyDecayReset  = 25'd16776520;
  localparam logic [23:0] ClickGainReset  = 24'd5033164;
  localparam logic [24:0] ClickDecayReset = 25'd16701173;

  typedef enum logic [2:0] {
    REG_FREQ        = 3'd0,
    REG_DAMP        = 3'd1,
    REG_BODY_DECAY  = 3'd2,
    REG_CLICK_GAIN  = 3'd3,
    REG_CLICK_DECAY = 3'd4
  } reg_idx_e;

  // Order of the eight products worked out for one sample.
  typedef enum logic [2:0] {
    OP_LOWPASS    = 3'd0,
    OP_HIGHPASS   = 3'd1,
    OP_BANDPASS   = 3'd2,
    OP_BODY       = 3'd3,
    OP_BODY_ENV   = 3'd4,
    OP_CLICK_GAIN = 3'd5,
    OP_CLICK      = 3'd6,
    OP_CLICK_ENV  = 3'd7
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_RUN  = 5'b00100,
    S_OUT  = 5'b01000,
    S_WAIT = 5'b10000
  } state_e;

  // Request to the multiplier.
  typedef struct packed {
    logic                     start;
    logic signed [MulAW-1:0]  a;
    logic        [MulBW-1:0]  b;
  } mul_req_t;

  // Saturate a non-negative Q24 product to the envelope width.
  function automatic logic [24:0] env_sat(input logic [StateW-1:0] v);
    logic [24:0] r;
    if (v[StateW-1:CoefW] != '0) r = EnvMax;
    else                         r = v[CoefW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/rfdv_if.sv]
// Valid/ready channel interfaces for the drum voice input and output items.
// Depends on nothing; used by the top level.
`default_nettype none

interface rfdv_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] velocity;
  logic signed [25:0] noise_sample;

  modport source (output valid, func, velocity, noise_sample, input ready);
  modport sink   (input valid, func, velocity, noise_sample, output ready);
endinterface

interface rfdv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] audio_out;

  modport source (output valid, audio_out, input ready);
  modport sink   (input valid, audio_out, output ready);
endinterface

`default_nettype wire

[rtl/resonant_filter_drum_voice.sv]
// Resonant state-variable filter drum voice, top level.
// Depends on rfdv_pkg, rfdv_in_if, rfdv_out_if and rfdv_digit_mul.
//
// Usage:
//   in_if carries one sample tick per transfer: func, velocity and
//   noise_sample. With func set, the tick is preceded by a trigger that
//   restarts both envelopes and kicks the filter. out_if carries one
//   audio_out sample for every input transfer, in order.
//   The five Q24 coefficients sit on an APB-style port at byte addresses
//   0, 4, 8, 12 and 16; write them only while the voice is idle.
// Schedule:
//   Each sample needs eight Q24 products, all run in turn on one multiplier
//   that consumes four bits of its second operand per cycle. Each product
//   is an operand load, seven digit steps and a write-back, and a new input
//   is taken only once the previous sample has reached the output register.
// Reset:
//   Filter states and envelopes clear to zero, coefficients return to their
//   defaults, and both channels go idle.
// Stalls:
//   The result waits in an output register; the next input transfer is
//   still taken. A finished sample waits in a hold state until that
//   register is free.
`default_nettype none

module resonant_filter_drum_voice import rfdv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  rfdv_in_if.sink           in_if,
  rfdv_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  // Coefficient registers.
  logic [CoefW-1:0] freq_q, damp_q, body_decay_q, click_decay_q;
  logic [GainW-1:0] click_gain_q;

  // Voice state.
  logic [StateW-1:0] lp_q, bp_q;
  logic [CoefW-1:0]  body_env_q, click_env_q;

  // Per-sample working registers.
  logic [ImpW-1:0]          impulse_q;
  logic signed [NoiseW-1:0] noise_q;
  logic [StateW-1:0]        tmp_q;
  logic [StateW-1:0]        acc_q;

  state_e state_q, state_d;
  op_e    op_q;

  logic              out_valid_q;
  logic [OutW-1:0]   audio_q;

  mul_req_t          mul_req;
  logic              mul_done;
  logic [StateW-1:0] prod;

  logic              in_xfer;
  logic              out_free;
  logic              cfg_wr;
  logic [CoefW-1:0]  vel_clamp;
  logic [OutW-1:0]   audio_sat;

  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Configuration writes and reads.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q        <= FreqReset;
      damp_q        <= DampReset;
      body_decay_q  <= BodyDecayReset;
      click_gain_q  <= ClickGainReset;
      click_decay_q <= ClickDecayReset;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[4:2]))
        REG_FREQ:        freq_q        <= pwdata[CoefW-1:0];
        REG_DAMP:        damp_q        <= pwdata[CoefW-1:0];
        REG_BODY_DECAY:  body_decay_q  <= pwdata[CoefW-1:0];
        REG_CLICK_GAIN:  click_gain_q  <= pwdata[GainW-1:0];
        REG_CLICK_DECAY: click_decay_q <= pwdata[CoefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      REG_FREQ:        prdata = DataW'(freq_q);
      REG_DAMP:        prdata = DataW'(damp_q);
      REG_BODY_DECAY:  prdata = DataW'(body_decay_q);
      REG_CLICK_GAIN:  prdata = DataW'(click_gain_q);
      REG_CLICK_DECAY: prdata = DataW'(click_decay_q);
      default:         prdata = '0;
    endcase
  end

  // Velocity clamped to 0..1.0 in Q24.
  always_comb begin
    priority if (in_if.velocity[VelW-1])                         vel_clamp = '0;
    else if ($unsigned(in_if.velocity) > VelW'(OneQ24))         vel_clamp = OneQ24;
    else                                                        vel_clamp = in_if.velocity[CoefW-1:0];
  end

  // Sequencer.
  assign in_if.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_xfer) state_d = S_LOAD;
      S_LOAD: state_d = S_RUN;
      S_RUN:  if (mul_done) state_d = (op_q == OP_CLICK_ENV) ? S_OUT : S_LOAD;
      S_OUT:  state_d = out_free ? S_IDLE : S_WAIT;
      S_WAIT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_LOWPASS;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        op_q <= OP_LOWPASS;
      end else if (state_q == S_RUN && mul_done) begin
        op_q <= op_e'(op_q + 3'd1);
      end
    end
  end

  // Operand selection for the multiplier.
  always_comb begin
    mul_req.start = (state_q == S_LOAD);
    unique case (op_q)
      OP_LOWPASS:    begin mul_req.a = bp_q;                 mul_req.b = freq_q;        end
      OP_HIGHPASS:   begin mul_req.a = bp_q;                 mul_req.b = damp_q;        end
      OP_BANDPASS:   begin mul_req.a = tmp_q;                mul_req.b = freq_q;        end
      OP_BODY:       begin mul_req.a = bp_q;                 mul_req.b = body_env_q;    end
      OP_BODY_ENV:   begin mul_req.a = MulAW'(body_env_q);   mul_req.b = body_decay_q;  end
      OP_CLICK_GAIN: begin
        mul_req.a = MulAW'(noise_q);
        mul_req.b = MulBW'(click_gain_q);
      end
      OP_CLICK:      begin mul_req.a = tmp_q;                mul_req.b = click_env_q;   end
      OP_CLICK_ENV:  begin mul_req.a = MulAW'(click_env_q);  mul_req.b = click_decay_q; end
      default:       begin mul_req.a = '0;                   mul_req.b = '0;            end
    endcase
  end

  rfdv_digit_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  // Voice state: trigger on input transfer, updates on the lowpass, bandpass and envelope products.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q        <= '0;
      bp_q        <= '0;
      body_env_q  <= '0;
      click_env_q <= '0;
    end else if (in_xfer) begin
      if (in_if.func) begin
        body_env_q  <= OneQ24;
        click_env_q <= vel_clamp;
      end
    end else if (state_q == S_RUN && mul_done) begin
      unique case (op_q)
        OP_LOWPASS:   lp_q        <= lp_q + prod;
        OP_BANDPASS:  bp_q        <= bp_q + prod;
        OP_BODY_ENV:  body_env_q  <= env_sat(prod);
        OP_CLICK_ENV: click_env_q <= env_sat(prod);
        default: ;
      endcase
    end
  end

  // Working registers for one sample.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      noise_q   <= in_if.noise_sample;
      impulse_q <= in_if.func ? ImpW'(vel_clamp) * ImpW'(KickGain) : '0;
    end else if (state_q == S_RUN && mul_done) begin
      unique case (op_q)
        OP_HIGHPASS:   tmp_q <= StateW'(impulse_q) - lp_q - prod;
        OP_BODY:       acc_q <= prod;
        OP_CLICK_GAIN: tmp_q <= prod;
        OP_CLICK:      acc_q <= acc_q + prod;
        default: ;
      endcase
    end
  end

  // Output scaling with saturation to 16 bits.
  always_comb begin
    if (acc_q[StateW-1:OutShift+OutW-1] != {(StateW-OutShift-OutW+1){acc_q[StateW-1]}}) begin
      audio_sat = acc_q[StateW-1] ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
    end else begin
      audio_sat = acc_q[OutShift +: OutW];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_OUT || state_q == S_WAIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT || state_q == S_WAIT) && out_free) begin
      audio_q <= audio_sat;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.audio_out = audio_q;

  // Checks on the sequencer and the multiplier hand-off.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_RUN)
    else $error("multiplier finished outside the run state");

  a_start_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_LOAD && op_q == OP_LOWPASS)
    else $error("sample did not start with the lowpass product");

  a_trigger_env: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_if.func |=> body_env_q == OneQ24)
    else $error("trigger did not restart the body envelope");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT || state_q == S_WAIT))
    else $error("output became valid without a finished sample");

endmodule

`default_nettype wire

[rtl/rfdv_digit_mul.sv]
// Digit-serial Q24 multiplier: signed 32-bit operand times unsigned 25-bit operand.
// Returns the product shifted right by 24 (floor) and wrapped to 32 bits. Uses rfdv_pkg.
`default_nettype none

module rfdv_digit_mul import rfdv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mul_req_t                 req_i,
  output logic                     done_o,
  output logic [StateW-1:0]        prod_o
);

  logic signed [MulAW-1:0]   a_q;
  logic        [MulBPadW-1:0] b_q;
  logic signed [MulAccW-1:0] p_q;
  logic        [MulBPadW-1:0] l_q;
  logic        [DigCntW-1:0]  cnt_q;
  logic                       busy_q;
  logic                       done_q;

  logic signed [DigitW:0]     digit;
  logic signed [MulAccW-1:0]  part;
  logic signed [MulAccW-1:0]  sum;

  // One digit of the multiplier operand times the whole multiplicand.
  assign digit = $signed({1'b0, b_q[DigitW-1:0]});
  assign part  = MulAccW'(a_q * digit);
  assign sum   = p_q + part;

  // Control: a run of NumDigits steps, then a one-cycle done flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DigCntW'(NumDigits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the high part accumulates, low digits shift out into l_q.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= MulBPadW'(req_i.b);
      p_q <= '0;
      l_q <= '0;
    end else if (busy_q) begin
      b_q <= b_q >> DigitW;
      l_q <= {sum[DigitW-1:0], l_q[MulBPadW-1:DigitW]};
      p_q <= sum >>> DigitW;
    end
  end

  // Bits 55..24 of the full product.
  assign prod_o = {p_q[StateW-MulBPadW+Q24Shift-1:0],
                   l_q[MulBPadW-1:Q24Shift]};
  assign done_o = done_q;

endmodule

`default_nettype wire

[verif/resonant_filter_drum_voice_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the resonant drum voice: drives sample ticks and triggers,
// predicts every output sample in Q24 and compares it. Depends on rfdv_pkg and rfdv_if.sv.

module resonant_filter_drum_voice_tb;
  import rfdv_pkg::*;

  // Input field codes and stimulus limits.
  localparam logic FuncTick    = 1'b0;
  localparam logic FuncTrigger = 1'b1;
  localparam int   NoiseMax      = 16777216;
  localparam int   ClickGainHigh = 10066329;
  localparam logic [AddrW-1:0] UnmappedAddr = {3'd7, 2'b00};

  // Predictor constants in 64-bit signed form.
  localparam longint OneVal   = longint'(OneQ24);
  localparam longint EnvCeil  = longint'(EnvMax);
  localparam longint KickVal  = KickGain;

  // Run control.
  localparam int IdleLimit    = 4000;
  localparam int SettleCycles = 200;
  localparam int HoldCycles   = 400;
  localparam int PrintLimit   = 200;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  rfdv_in_if  in_if ();
  rfdv_out_if out_if ();

  resonant_filter_drum_voice dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the coefficients and of the voice state.
  longint freq_q24;
  longint damp_q24;
  longint body_decay_q24;
  longint click_gain_q24;
  longint click_decay_q24;
  int     lowpass_acc;
  int     bandpass_acc;
  longint body_env;
  longint click_env;

  logic signed [OutW-1:0] expected_audio[$];
  int error_count;
  int sample_index;
  int idle_cycles;
  int rx_hold_cycles;
  bit rx_steady;
  bit tx_steady;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Q24 product: exact 64-bit product, floor shift, wrapped to 32 bits.
  function automatic int q24_product(input longint a, input longint b);
    longint p;
    p = (a * b) >>> Q24Shift;
    return int'(p);
  endfunction

  function automatic longint env_clamp(input int v);
    if (v < 0) return 0;
    if (longint'(v) > EnvCeil) return EnvCeil;
    return longint'(v);
  endfunction

  // Advances the voice by one tick and returns the output sample it produces.
  function automatic logic signed [OutW-1:0] voice_next_sample(
      input logic trig, input logic signed [VelW-1:0] vel_in,
      input logic signed [NoiseW-1:0] noise_in);
    longint vel;
    longint impulse;
    longint noise;
    longint scaled;
    int     high;
    int     body;
    int     click;
    int     mix;
    impulse = 0;
    noise   = longint'(noise_in);
    if (trig == FuncTrigger) begin
      vel = longint'(vel_in);
      if (vel < 0) vel = 0;
      if (vel > OneVal) vel = OneVal;
      impulse   = vel * KickVal;
      body_env  = OneVal;
      click_env = vel;
    end
    // Chamberlin filter update; all sums wrap at 32 bits.
    lowpass_acc  = lowpass_acc + q24_product(freq_q24, bandpass_acc);
    high = int'(impulse - longint'(lowpass_acc) -
                longint'(q24_product(damp_q24, bandpass_acc)));
    bandpass_acc = bandpass_acc + q24_product(freq_q24, high);
    // Body and click paths with their envelopes.
    body     = q24_product(bandpass_acc, body_env);
    body_env = env_clamp(q24_product(body_env, body_decay_q24));
    click     = q24_product(noise, click_gain_q24);
    click     = q24_product(click, click_env);
    click_env = env_clamp(q24_product(click_env, click_decay_q24));
    // Mix, scale down and saturate to 16 bits.
    mix    = body + click;
    scaled = longint'(mix) >>> OutShift;
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32768) scaled = -32768;
    return scaled[OutW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] coeff_addr(input reg_idx_e idx);
    return {idx, 2'b00};
  endfunction

  function automatic logic signed [NoiseW-1:0] rand_noise();
    int v;
    v = int'($urandom_range(2 * NoiseMax, 0)) - NoiseMax;
    return v[NoiseW-1:0];
  endfunction

  // Mostly in-range velocities, with out-of-range and boundary values mixed in.
  function automatic logic signed [VelW-1:0] rand_velocity();
    int unsigned pick;
    pick = $urandom_range(9, 0);
    if (pick < 7) return $urandom_range(OneQ24, 0);
    if (pick == 7) return $urandom();
    case ($urandom_range(3, 0))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return OneQ24 + 1;
      default: return -1;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PrintLimit) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // One input transfer, after a random gap unless tx_steady is set; the expected sample is queued on acceptance.
  task automatic drive_sample(input logic trig, input logic signed [VelW-1:0] vel,
                              input logic signed [NoiseW-1:0] noise);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(15, 0);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= trig;
    in_if.velocity     <= vel;
    in_if.noise_sample <= noise;
    do @(posedge clk_i); while (!in_if.ready);
    expected_audio.push_back(voice_next_sample(trig, vel, noise));
  endtask

  // Stops offering input and waits until every expected sample has come back.
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (expected_audio.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup phase, access phase until pready, then the bus returns to idle.
  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (addr[1:0] == 2'b00) begin
      case (addr[AddrW-1:2])
        REG_FREQ:        freq_q24        = longint'(data[CoefW-1:0]);
        REG_DAMP:        damp_q24        = longint'(data[CoefW-1:0]);
        REG_BODY_DECAY:  body_decay_q24  = longint'(data[CoefW-1:0]);
        REG_CLICK_GAIN:  click_gain_q24  = longint'(data[GainW-1:0]);
        REG_CLICK_DECAY: click_decay_q24 = longint'(data[CoefW-1:0]);
        default: ;
      endcase
    end
  endtask

  task automatic set_coefficients(input logic [DataW-1:0] freq, input logic [DataW-1:0] damp,
                                  input logic [DataW-1:0] body_decay,
                                  input logic [DataW-1:0] gain,
                                  input logic [DataW-1:0] click_decay);
    wait_results_drained();
    apb_write(coeff_addr(REG_FREQ), freq);
    apb_write(coeff_addr(REG_DAMP), damp);
    apb_write(coeff_addr(REG_BODY_DECAY), body_decay);
    apb_write(coeff_addr(REG_CLICK_GAIN), gain);
    apb_write(coeff_addr(REG_CLICK_DECAY), click_decay);
  endtask

  // Drum hits: a trigger, a decaying tail of plain ticks, now and then a stray trigger.
  task automatic play_hits(input int unsigned count);
    int unsigned until_hit;
    until_hit = 0;
    repeat (count) begin
      if (until_hit == 0) begin
        drive_sample(FuncTrigger, rand_velocity(), rand_noise());
        until_hit = $urandom_range(48, 4);
      end else begin
        drive_sample(($urandom_range(15, 0) == 0) ? FuncTrigger : FuncTick,
                     $urandom(), rand_noise());
        until_hit--;
      end
    end
  endtask

  // Reset defaults: silence, velocity clamping at both ends, noise extremes.
  task automatic test_directed_edges();
    drive_sample(FuncTick, 0, 0);
    drive_sample(FuncTick, 0, NoiseMax);
    drive_sample(FuncTick, 0, -NoiseMax);
    drive_sample(FuncTrigger, OneQ24, NoiseMax);
    drive_sample(FuncTick, 0, -NoiseMax);
    drive_sample(FuncTick, 0, 0);
    drive_sample(FuncTrigger, 32'sh7FFF_FFFF, -1);
    drive_sample(FuncTick, 0, NoiseMax);
    drive_sample(FuncTrigger, OneQ24 + 1, -NoiseMax);
    drive_sample(FuncTrigger, 32'sh8000_0000, NoiseMax);
    drive_sample(FuncTick, 0, NoiseMax);
    drive_sample(FuncTrigger, -1, -NoiseMax);
    drive_sample(FuncTrigger, 0, NoiseMax);
    drive_sample(FuncTick, 32'shFFFF_FFFF, NoiseMax);
    drive_sample(FuncTrigger, 1, NoiseMax);
    drive_sample(FuncTrigger, OneQ24, -NoiseMax);
    repeat (6) drive_sample(FuncTick, $urandom(), rand_noise());
  endtask

  // Coefficients at their range limits, at full register width, at zero, and an
  // unmapped address that must leave every coefficient alone.
  task automatic test_coefficient_extremes();
    set_coefficients(OneQ24, OneQ24, OneQ24, ClickGainHigh, OneQ24);
    play_hits(16);
    // Decay factors near two drive both envelopes into saturation.
    set_coefficients('1, '1, '1, '1, '1);
    play_hits(16);
    set_coefficients('0, '0, '0, '0, '0);
    play_hits(12);
    set_coefficients(FreqReset, DampReset, BodyDecayReset, ClickGainReset, ClickDecayReset);
    wait_results_drained();
    apb_write(UnmappedAddr, 32'h0123_4567);
    play_hits(8);
  endtask

  // Several random settings, alternating musical and unrestricted coefficients.
  task automatic test_random_settings();
    for (int round = 0; round < 5; round++) begin
      if (round % 2 == 0) begin
        set_coefficients($urandom_range(600000, 60000), $urandom_range(6000000, 500000),
                         $urandom_range(OneQ24, 16700000), $urandom_range(ClickGainHigh, 0),
                         $urandom_range(OneQ24, 16200000));
      end else begin
        set_coefficients($urandom_range(OneQ24, 0), $urandom_range(OneQ24, 0),
                         $urandom_range(OneQ24, 0), $urandom_range(ClickGainHigh, 0),
                         $urandom_range(OneQ24, 0));
      end
      play_hits(220);
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the voice stalls its input.
  task automatic test_output_backpressure();
    rx_hold_cycles = HoldCycles;
    tx_steady = 1'b1;
    play_hits(40);
    tx_steady = 1'b0;
  endtask

  // Bursts separated by full drains of the pipeline.
  task automatic test_drain_pause();
    repeat (3) begin
      play_hits(20);
      wait_results_drained();
    end
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_steady_stream();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    play_hits(100);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Output ready: random stall per sample, or a long hold when one is requested.
  initial begin : audio_ready_driver
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      stall = rx_steady ? 0 : $urandom_range(15, 0);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i);
      while (!(out_if.valid && out_if.ready) && rx_hold_cycles == 0);
    end
  end

  // Compares each output transfer with the oldest expected sample.
  always @(posedge clk_i) begin : audio_checker
    logic signed [OutW-1:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_audio.size() == 0) begin
        report_mismatch($sformatf("sample %0d: unexpected audio_out %0d",
                                  sample_index, out_if.audio_out));
      end else begin
        want = expected_audio.pop_front();
        if (out_if.audio_out !== want)
          report_mismatch($sformatf("sample %0d: audio_out %0d, expected %0d",
                                    sample_index, out_if.audio_out, want));
      end
      sample_index++;
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin : stall_watchdog
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("resonant_filter_drum_voice regression: fail");
        $finish;
      end
    end
  end

  initial begin : regression
    error_count     = 0;
    sample_index    = 0;
    idle_cycles     = 0;
    rx_hold_cycles  = 0;
    rx_steady       = 1'b0;
    tx_steady       = 1'b0;
    freq_q24        = longint'(FreqReset);
    damp_q24        = longint'(DampReset);
    body_decay_q24  = longint'(BodyDecayReset);
    click_gain_q24  = longint'(ClickGainReset);
    click_decay_q24 = longint'(ClickDecayReset);
    lowpass_acc     = 0;
    bandpass_acc    = 0;
    body_env        = 0;
    click_env       = 0;
    rst_ni = 1'b0;
    in_if.valid        <= 1'b0;
    in_if.func         <= FuncTick;
    in_if.velocity     <= '0;
    in_if.noise_sample <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_coefficient_extremes();
    test_random_settings();
    test_output_backpressure();
    test_drain_pause();
    test_steady_stream();

    wait_results_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("resonant_filter_drum_voice regression: pass");
    end else begin
      $display("resonant_filter_drum_voice regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rfdv_pkg.sv
rtl/rfdv_if.sv
rtl/rfdv_digit_mul.sv
rtl/resonant_filter_drum_voice.sv
verif/resonant_filter_drum_voice_tb.sv
